// File: rtl/core/bmla_pkg.sv
// ----------------------------------------------------------------------------
// bmla_pkg
// Shared constants, types and helper functions for the binary matrix local
// alignment block.
// ----------------------------------------------------------------------------
package bmla_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int SIZE_W     = 11;
    localparam int SCORE_W    = 14;
    localparam int TERM_W     = SCORE_W + 2;
    localparam int SCORE_MAX  = 16383;
    localparam int MATCH      = 10;
    localparam int GAP_OPEN   = 5;
    localparam int GAP_EXT    = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic               sim;
        logic [SCORE_W-1:0] score;
    } t_cell;

    // one column of the line buffer: top is the previous row, bot the one before
    typedef struct packed {
        t_cell top;
        t_cell bot;
    } t_col;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            res = SIZE_W'(maxv);
        end
        return res;
    endfunction

    function automatic logic signed [TERM_W-1:0] pred_term(input t_cell p, input logic cur);
        logic signed [TERM_W-1:0] h;
        h = $signed({2'b00, p.score});
        if (cur) begin
            h = h + TERM_W'(MATCH);
        end else if (p.sim) begin
            h = h - TERM_W'(MATCH + GAP_OPEN);
        end else begin
            h = h - TERM_W'(MATCH + GAP_EXT);
        end
        return h;
    endfunction

endpackage

// File: rtl/core/bmla_if.sv
// ----------------------------------------------------------------------------
// bmla channel interfaces
// Valid/ready channels for matrix cells in and alignment scores out.
// ----------------------------------------------------------------------------
interface bmla_cell_if;
    import bmla_pkg::*;
    logic valid;
    logic ready;
    logic similar;

    modport source (output valid, output similar, input ready);
    modport sink   (input valid, input similar, output ready);
endinterface

interface bmla_score_if;
    import bmla_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] best_score;

    modport source (output valid, output best_score, input ready);
    modport sink   (input valid, input best_score, output ready);
endinterface

// File: rtl/core/binary_matrix_local_alignment.sv
// ----------------------------------------------------------------------------
// binary_matrix_local_alignment
// Local alignment score over a streamed binary similarity matrix, two-row
// line buffer in a single-port-write, registered-read memory.
//
//   channel   dir   handshake        word
//   i_cell    in    valid/ready      similar (1 bit), row-major cells
//   o_score   out   valid/ready      best_score (14 bits), once per matrix
//   apb       in    psel/penable     rows @0x0, cols @0x4
//
// one cell per cycle: the line buffer is read at accept, the score is
// computed and written back in the next cycle, with forwarding for a
// same-column read and write. the result goes to a two-word output queue;
// the last cell of a matrix waits only while no queue slot is sure to be free.
// reset: sizes 1024, position and best cleared; no memory clearing pass.
// ----------------------------------------------------------------------------
module binary_matrix_local_alignment
    import bmla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bmla_cell_if.sink             i_cell,
    bmla_score_if.source          o_score,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [SIZE_W-1:0]  r_rows;
    logic [SIZE_W-1:0]  r_cols;
    logic [SIZE_W-1:0]  nr;
    logic [SIZE_W-1:0]  nc;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               col_end;
    logic               row_end;
    logic               in_last;
    logic               out_free;
    logic               out_pop;
    logic               out_push;
    logic               out_take;
    logic               acc;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    t_col               r_mem [MAX_COLS];
    t_col               r_rdata;
    logic               r_fwd;
    t_col               r_fwd_data;
    t_col               col_data;
    t_col               wdata;

    logic               r_s1_valid;
    logic               r_s1_cur;
    logic [COL_W-1:0]   r_s1_col;
    logic               r_s1_inner;
    logic               r_s1_last;
    t_col               r_prev_a;
    t_cell              r_prev_b;

    logic signed [TERM_W-1:0] t1;
    logic signed [TERM_W-1:0] t2;
    logic signed [TERM_W-1:0] t3;
    logic signed [TERM_W-1:0] hmax;
    logic [SCORE_W-1:0] score;
    logic [SCORE_W-1:0] best_upd;

    logic [SCORE_W-1:0] r_best;
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_skid_valid;
    logic [SCORE_W-1:0] r_skid_score;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_ROWS: prdata = CFG_DATA_W'(r_rows);
            REG_COLS: prdata = CFG_DATA_W'(r_cols);
            default:  prdata = '0;
        endcase
    end

    assign nr = eff_size(r_rows, MAX_ROWS);
    assign nc = eff_size(r_cols, MAX_COLS);

    assign col_end = (32'(r_col) + 32'd1) == 32'(nc);
    assign row_end = (32'(r_row) + 32'd1) == 32'(nr);
    assign in_last = col_end && row_end;

    // last cell only goes in when an output slot is sure to be free
    assign out_pop      = r_out_valid && o_score.ready;
    assign out_push     = r_s1_valid && r_s1_last;
    assign out_take     = !r_out_valid || out_pop;
    assign out_free     = r_skid_valid ? (out_pop && !out_push) : (out_take || !out_push);
    assign i_cell.ready = !in_last || out_free;
    assign acc          = i_cell.valid && i_cell.ready;

    assign o_score.valid      = r_out_valid;
    assign o_score.best_score = r_out_score;

    // score of the cell in stage one
    assign col_data = r_fwd ? r_fwd_data : r_rdata;

    always_comb begin
        t1   = pred_term(r_prev_a.top, r_s1_cur);
        t2   = pred_term(r_prev_a.bot, r_s1_cur);
        t3   = pred_term(r_prev_b, r_s1_cur);
        hmax = '0;
        if (t1 > hmax) begin
            hmax = t1;
        end
        if (t2 > hmax) begin
            hmax = t2;
        end
        if (t3 > hmax) begin
            hmax = t3;
        end
        if (hmax > TERM_W'(SCORE_MAX)) begin
            hmax = TERM_W'(SCORE_MAX);
        end
        score = r_s1_inner ? hmax[SCORE_W-1:0] : '0;
        best_upd = (score > r_best) ? score : r_best;
        wdata.top.sim   = r_s1_cur;
        wdata.top.score = score;
        wdata.bot       = col_data.top;
    end

    // line buffer
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rdata <= r_mem[r_col];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= wdata;
        end
        r_fwd_data <= wdata;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_prev_a <= col_data;
            r_prev_b <= r_prev_a.top;
        end
        if (acc) begin
            r_s1_cur   <= i_cell.similar;
            r_s1_col   <= r_col;
            r_s1_inner <= (32'(r_row) >= 32'd2) && (32'(r_col) >= 32'd2);
            r_s1_last  <= in_last;
        end
        if (out_take) begin
            if (r_skid_valid) begin
                r_out_score <= r_skid_score;
            end else if (out_push) begin
                r_out_score <= best_upd;
            end
        end
        if (out_push && (!out_take || r_skid_valid)) begin
            r_skid_score <= best_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= SIZE_W'(1024);
            r_cols       <= SIZE_W'(1024);
            r_row        <= '0;
            r_col        <= '0;
            r_best       <= '0;
            r_s1_valid   <= 1'b0;
            r_fwd        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            r_fwd      <= acc && r_s1_valid && (r_s1_col == r_col);

            if (cfg_wr) begin
                case (cfg_idx)
                    REG_ROWS: r_rows <= pwdata[SIZE_W-1:0];
                    REG_COLS: r_cols <= pwdata[SIZE_W-1:0];
                    default:  r_rows <= r_rows;
                endcase
                r_row  <= '0;
                r_col  <= '0;
                r_best <= '0;
            end else begin
                if (acc) begin
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= row_end ? '0 : r_row + ROW_W'(1);
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end

                if (r_s1_valid) begin
                    r_best <= r_s1_last ? '0 : best_upd;
                end
            end

            if (out_take) begin
                r_out_valid  <= r_skid_valid || out_push;
                r_skid_valid <= r_skid_valid && out_push;
            end else if (out_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule
